### sv/stp_pkg.sv
// Shared constants, types and helpers of the shelf tile packer.
package stp_pkg;

	localparam int MAX_SHELVES = 64;
	localparam int PADDING     = 1;
	localparam int MAX_TILE    = 256;
	localparam int MAX_HEIGHT  = 4096;

	localparam int WIDTH_LIMIT = 4096;
	localparam int HEIGHT_MIN  = 16;
	localparam int HEIGHT_MAX  = 4096;
	localparam int RESET_WIDTH = 1024;
	localparam int RESERVED    = 1 + 2 * PADDING;

	localparam int IN_W    = 9;
	localparam int CFG_W   = 13;
	localparam int POS_W   = 12;
	localparam int AH_W    = 13;
	localparam int XW      = 13;
	localparam int YW      = $clog2(MAX_HEIGHT + 1);
	localparam int PDIM_W  = $clog2(MAX_TILE + 2 * PADDING + 1);
	localparam int IDX_W   = $clog2(MAX_SHELVES);
	localparam int CNT_W   = $clog2(MAX_SHELVES + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [PDIM_W-1:0] tw;
		logic [PDIM_W-1:0] th;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	typedef struct packed {
		logic [XW-1:0]     next_x;
		logic [YW-1:0]     top_y;
		logic [PDIM_W-1:0] height;
	} shelf_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN
	} back_state_t;

	function automatic logic [AH_W-1:0] round_height(input logic [YW-1:0] h);
		logic [AH_W-1:0] p;
		p = AH_W'(HEIGHT_MAX);
		for (int k = $clog2(HEIGHT_MAX) - 1; k >= $clog2(HEIGHT_MIN); k--) begin
			if (32'(h) <= (32'd1 << k)) begin
				p = AH_W'(32'd1 << k);
			end
		end
		return p;
	endfunction

endpackage

### sv/shelf_tile_packer_unit.sv
// Top level of the shelf tile packer: front end, shelf search back end, config register.
//
// Input words on s_axis carry one tile size each; output words on m_axis carry one
// placement result per tile, in order. The user writes atlas_width with cfg_we/cfg_wdata
// only while the block is idle (not enforced here); it applies to every later tile.
// The front end clamps and pads each tile and queues up to two tiles; s_axis_tready
// drops only when that queue is full. The back end scans the shelves in order, one
// shelf RAM read per cycle, and registers the result in the output register when the
// scan ends; it takes a new tile only after the last one is done. Throughput is set by
// this shelf scan.
// A held result (m_axis_tready low) keeps the next tile from entering the scan; the
// queue keeps accepting until full.
// After arst_n the back end writes the reserved shelf 0 in its INIT state, then takes
// tiles; atlas_width resets to 1024 and the atlas holds only the reserved tile.
module shelf_tile_packer_unit
	import stp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [23:0]      s_axis_tdata,  // tile_width[8:0], tile_height[17:9], zero
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // pos_x[11:0], pos_y[23:12], atlas_height[36:24]
	output logic             m_axis_tuser,  // placed
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	queue_out_t       q_out;
	logic             q_pop;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic [AH_W-1:0]  atlas_height;

	stp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_width  (s_axis_tdata[8:0]),
		.in_height (s_axis_tdata[17:9]),
		.q_out     (q_out),
		.q_pop     (q_pop)
	);

	stp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_in       (q_out),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_placed (m_axis_tuser),
		.out_pos_x  (pos_x),
		.out_pos_y  (pos_y),
		.out_height (atlas_height)
	);

	assign m_axis_tdata = {3'b000, atlas_height, pos_y, pos_x};

endmodule

### sv/stp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/stp_front.sv
// Front end: accepts tile words, clamps and pads sizes, queues them for the back end.
module stp_front
	import stp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [IN_W-1:0] in_width,
	input  logic [IN_W-1:0] in_height,
	output queue_out_t   q_out,
	input  logic         q_pop
);

	function automatic logic [PDIM_W-1:0] clamp_pad(input logic [IN_W-1:0] v);
		logic [31:0] d;
		d = 32'(v);
		if (d < 32'd1) begin
			d = 32'd1;
		end
		if (d > 32'(MAX_TILE)) begin
			d = 32'(MAX_TILE);
		end
		return PDIM_W'(d + 32'(2 * PADDING));
	endfunction

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && (cnt_q != '0);

	assign q_out.valid = (cnt_q != '0);
	assign q_out.item  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q].tw <= clamp_pad(in_width);
			entry_q[wr_q].th <= clamp_pad(in_height);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/stp_back.sv
// Back end: first-fit shelf search over the shelf RAM, shelf update and result register.
module stp_back
	import stp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  queue_out_t       q_in,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_placed,
	output logic [POS_W-1:0] out_pos_x,
	output logic [POS_W-1:0] out_pos_y,
	output logic [AH_W-1:0]  out_height
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [CFG_W-1:0]  aw_cfg_q;
	logic [XW-1:0]     aw;
	logic [IDX_W-1:0]  s_q;
	logic [PDIM_W-1:0] tw_q;
	logic [PDIM_W-1:0] th_q;
	logic [CNT_W-1:0]  count_q;
	logic [YW-1:0]     used_q;

	logic              valid_q;
	logic              placed_q;
	logic [POS_W-1:0]  pos_x_q;
	logic [POS_W-1:0]  pos_y_q;
	logic [AH_W-1:0]   height_q;

	logic              out_free;
	logic              fit;
	logic              last;
	logic              done;
	logic              new_ok;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	shelf_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	shelf_t            shelf;
	logic [31:0]       fit_x;
	logic [31:0]       new_y;
	logic [YW-1:0]     used_next;

	stp_ram #(
		.WIDTH($bits(shelf_t)),
		.DEPTH(MAX_SHELVES)
	) u_shelf_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (shelf)
	);

	assign aw       = (32'(aw_cfg_q) > WIDTH_LIMIT) ? XW'(WIDTH_LIMIT) : XW'(aw_cfg_q);
	assign out_free = !valid_q || out_ready;
	assign fit_x    = 32'(shelf.next_x) + 32'(tw_q);
	assign new_y    = 32'(used_q) + 32'(th_q);
	assign fit      = (fit_x <= 32'(aw)) && (th_q <= shelf.height);
	assign last     = ((CNT_W'(s_q) + 1'b1) == count_q);
	assign new_ok   = !fit && (32'(count_q) < MAX_SHELVES) && (32'(tw_q) <= 32'(aw))
		&& (new_y <= 32'(MAX_HEIGHT));
	assign used_next = (done && new_ok) ? YW'(new_y) : used_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: state_d = ST_IDLE;
			ST_IDLE: begin
				if (q_in.valid && out_free) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (fit || last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = s_q;
		ram_wdata = shelf;
		ram_raddr = s_q + 1'b1;
		case (state_q)
			ST_INIT: begin
				ram_we           = 1'b1;
				ram_waddr        = '0;
				ram_wdata.next_x = XW'(RESERVED);
				ram_wdata.top_y  = '0;
				ram_wdata.height = PDIM_W'(RESERVED);
			end
			ST_IDLE: begin
				q_pop     = q_in.valid && out_free;
				ram_raddr = '0;
			end
			ST_SCAN: begin
				done = fit || last;
				if (fit) begin
					ram_we           = 1'b1;
					ram_wdata.next_x = XW'(fit_x);
				end else if (last && new_ok) begin
					ram_we           = 1'b1;
					ram_waddr        = IDX_W'(count_q);
					ram_wdata.next_x = XW'(tw_q);
					ram_wdata.top_y  = used_q;
					ram_wdata.height = th_q;
				end
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tw_q <= q_in.item.tw;
			th_q <= q_in.item.th;
		end
		if (done) begin
			placed_q <= fit || new_ok;
			height_q <= round_height(used_next);
			if (fit) begin
				pos_x_q <= POS_W'(32'(shelf.next_x) + 32'(PADDING));
				pos_y_q <= POS_W'(32'(shelf.top_y) + 32'(PADDING));
			end else if (new_ok) begin
				pos_x_q <= POS_W'(PADDING);
				pos_y_q <= POS_W'(32'(used_q) + 32'(PADDING));
			end else begin
				pos_x_q <= '0;
				pos_y_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			aw_cfg_q <= CFG_W'(RESET_WIDTH);
			s_q      <= '0;
			count_q  <= CNT_W'(1);
			used_q   <= YW'(RESERVED);
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				aw_cfg_q <= cfg_wdata;
			end
			if (q_pop) begin
				s_q <= '0;
			end else if (state_q == ST_SCAN && !done) begin
				s_q <= s_q + 1'b1;
			end
			if (done && new_ok) begin
				count_q <= count_q + 1'b1;
			end
			used_q <= used_next;
			if (done) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_placed = placed_q;
	assign out_pos_x  = pos_x_q;
	assign out_pos_y  = pos_y_q;
	assign out_height = height_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (32'(count_q) <= MAX_SHELVES))
		else $error("shelf count out of range");

	a_scan_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_W'(s_q) < count_q))
		else $error("scan index past shelf count");

	a_used_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= MAX_HEIGHT)
		else $error("used height past limit");

	a_reject_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !fit && !new_ok) |=> (!placed_q && pos_x_q == '0 && pos_y_q == '0))
		else $error("rejected tile not at origin");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !valid_q || $past(out_ready) || $past(!valid_q))
		else $error("item started while result blocked");

endmodule
